@@ design/txtov_pkg.sv @@
// ----------------------------------------------------------------------------
// Text overlay compositor package
// Shared constants, palettes and color helpers for the pixel compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package txtov_pkg;

	localparam int SCREEN_WIDTH = 640;
	localparam int GLYPH_ROWS   = 8;
	localparam int FONT_DEPTH   = 256 * GLYPH_ROWS;
	localparam int FONT_AW      = $clog2(FONT_DEPTH);
	localparam int ROW_W        = $clog2(GLYPH_ROWS);

	localparam int X_W    = 10;
	localparam int Y_W    = 9;
	localparam int PIX_W  = 16;
	localparam int CODE_W = 8;
	localparam int ATTR_W = 8;
	localparam int BYTE_W = 8;
	localparam int MODE_W = 4;
	localparam int COL_W  = 3;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FONT  = 1'b1;

	localparam int MODE_MIX   = 1;
	localparam int MODE_COL80 = 2;
	localparam int MODE_ROW60 = 3;

	localparam logic [3:0] BG_KEEP = 4'h0;
	localparam logic [3:0] BG_DIM  = 4'h8;

	localparam logic [PIX_W-1:0] FG_PALETTE [16] = '{
		16'h0000, 16'h8000, 16'h0400, 16'h0010,
		16'h8400, 16'h0410, 16'h8010, 16'h4208,
		16'h8410, 16'hF800, 16'h07E0, 16'h001F,
		16'hFFE0, 16'h07FF, 16'hF81F, 16'hFFFF
	};

	localparam logic [PIX_W-1:0] BG_PALETTE [16] = '{
		16'h0000, 16'h8000, 16'h0400, 16'h0010,
		16'h8400, 16'h0410, 16'h8010, 16'h2104,
		16'h8410, 16'hF800, 16'h07E0, 16'h001F,
		16'hFFE0, 16'h07FF, 16'hF81F, 16'hFFFF
	};

	// Each RGB565 channel is shifted right by one.
	function automatic logic [PIX_W-1:0] halve565(input logic [PIX_W-1:0] p);
		return {1'b0, p[15:12], 1'b0, p[10:6], 1'b0, p[4:1]};
	endfunction

endpackage

`default_nettype wire

@@ design/txtov_if.sv @@
// ----------------------------------------------------------------------------
// Text overlay compositor channels
// Request, result and mode register channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface txtov_in_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [txtov_pkg::X_W-1:0]         pixel_x;
	logic [txtov_pkg::Y_W-1:0]         pixel_y;
	logic [txtov_pkg::CODE_W-1:0]      char_code;
	logic [txtov_pkg::ATTR_W-1:0]      char_attr;
	logic [txtov_pkg::PIX_W-1:0]       gfx_pixel;
	logic [txtov_pkg::FONT_AW-1:0]     font_addr;
	logic [txtov_pkg::BYTE_W-1:0]      font_data;

	modport source (
		output valid, req_type, pixel_x, pixel_y, char_code, char_attr,
		       gfx_pixel, font_addr, font_data,
		input  ready
	);
	modport sink (
		input  valid, req_type, pixel_x, pixel_y, char_code, char_attr,
		       gfx_pixel, font_addr, font_data,
		output ready
	);
endinterface

interface txtov_out_if;
	logic                          valid;
	logic                          ready;
	logic [txtov_pkg::PIX_W-1:0]   pixel_out;
	logic [txtov_pkg::X_W-1:0]     out_x;
	logic [txtov_pkg::Y_W-1:0]     out_y;

	modport source (output valid, pixel_out, out_x, out_y, input ready);
	modport sink   (input valid, pixel_out, out_x, out_y, output ready);
endinterface

interface txtov_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [txtov_pkg::MODE_W-1:0]  video_mode;

	modport source (output valid, video_mode, input ready);
	modport sink   (input valid, video_mode, output ready);
endinterface

`default_nettype wire

@@ design/text_overlay_pixel_compositor.sv @@
// ----------------------------------------------------------------------------
// Text overlay pixel compositor
// Composites a text cell glyph over an RGB565 graphics pixel, with a
// loadable font store.
//
// Channel   Dir  Payload
// pix_in    in   req_type, pixel_x, pixel_y, char_code, char_attr,
//                gfx_pixel, font_addr, font_data
// pix_out   out  pixel_out, out_x, out_y (one beat per pixel request)
// cfg       in   video_mode (always ready)
//
// One beat is accepted per cycle while the pipeline is not stalled; a pixel
// request passes the input registers, the font RAM read and the output
// register. The font RAM's registered read port sets the middle stage.
// Reset clears the mode register and all stage valid bits; the font store is
// undefined until written. Each stage advances when the next one is empty or
// advancing, so bubbles close up and a stalled beat is held, never dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module text_overlay_pixel_compositor (
	input  wire logic  clk,
	input  wire logic  arst_n,
	txtov_in_if.sink   pix_in,
	txtov_out_if.source pix_out,
	txtov_cfg_if.sink  cfg
);

	logic [txtov_pkg::MODE_W-1:0] mode_q;

	logic ld1, ld2, ld3;
	logic vld_s1, vld_s2, vld_s3;

	logic [txtov_pkg::COL_W-1:0]   col_in;
	logic [txtov_pkg::ROW_W-1:0]   row_in;
	logic                          inscr_in;

	logic                          wr_s1;
	logic [txtov_pkg::X_W-1:0]     x_s1;
	logic [txtov_pkg::Y_W-1:0]     y_s1;
	logic [txtov_pkg::ATTR_W-1:0]  attr_s1;
	logic [txtov_pkg::PIX_W-1:0]   gfx_s1;
	logic [txtov_pkg::COL_W-1:0]   col_s1;
	logic                          inscr_s1;
	logic [txtov_pkg::FONT_AW-1:0] raddr_s1;
	logic [txtov_pkg::FONT_AW-1:0] waddr_s1;
	logic [txtov_pkg::BYTE_W-1:0]  wdata_s1;

	logic [txtov_pkg::X_W-1:0]     x_s2;
	logic [txtov_pkg::Y_W-1:0]     y_s2;
	logic [txtov_pkg::ATTR_W-1:0]  attr_s2;
	logic [txtov_pkg::PIX_W-1:0]   gfx_s2;
	logic [txtov_pkg::COL_W-1:0]   col_s2;
	logic                          inscr_s2;
	logic [txtov_pkg::BYTE_W-1:0]  glyph_s2;

	logic [txtov_pkg::PIX_W-1:0]   pix_s3;
	logic [txtov_pkg::X_W-1:0]     x_s3;
	logic [txtov_pkg::Y_W-1:0]     y_s3;

	logic                          font_we;
	logic                          font_re;
	logic                          glyph_bit;
	logic [3:0]                    fg_idx;
	logic [3:0]                    bg_idx;
	logic [txtov_pkg::PIX_W-1:0]   pix_next;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg.valid) begin
			mode_q <= cfg.video_mode;
		end
	end

	assign ld3 = !vld_s3 || pix_out.ready;
	assign ld2 = !vld_s2 || ld3;
	assign ld1 = !vld_s1 || ld2;
	assign pix_in.ready = ld1;

	assign col_in = mode_q[txtov_pkg::MODE_COL80] ? pix_in.pixel_x[2:0]
	                                              : pix_in.pixel_x[3:1];
	assign row_in = mode_q[txtov_pkg::MODE_ROW60] ? pix_in.pixel_y[2:0]
	                                              : pix_in.pixel_y[3:1];
	assign inscr_in = {1'b0, pix_in.pixel_x} < (txtov_pkg::X_W + 1)'(txtov_pkg::SCREEN_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				vld_s1 <= pix_in.valid;
			end
			if (ld2) begin
				vld_s2 <= vld_s1 && (wr_s1 == txtov_pkg::REQ_PIXEL);
			end
			if (ld3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && pix_in.valid) begin
			wr_s1    <= pix_in.req_type;
			x_s1     <= pix_in.pixel_x;
			y_s1     <= pix_in.pixel_y;
			attr_s1  <= pix_in.char_attr;
			gfx_s1   <= pix_in.gfx_pixel;
			col_s1   <= col_in;
			inscr_s1 <= inscr_in;
			raddr_s1 <= {pix_in.char_code, row_in};
			waddr_s1 <= pix_in.font_addr;
			wdata_s1 <= pix_in.font_data;
		end
	end

	assign font_we = vld_s1 && ld2 && (wr_s1 == txtov_pkg::REQ_FONT);
	assign font_re = vld_s1 && ld2 && (wr_s1 == txtov_pkg::REQ_PIXEL);

	txtov_ram #(
		.WIDTH(txtov_pkg::BYTE_W),
		.DEPTH(txtov_pkg::FONT_DEPTH)
	) u_font (
		.clk  (clk),
		.we   (font_we),
		.waddr(waddr_s1),
		.wdata(wdata_s1),
		.re   (font_re),
		.raddr(raddr_s1),
		.rdata(glyph_s2)
	);

	always_ff @(posedge clk) begin
		if (font_re) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			attr_s2  <= attr_s1;
			gfx_s2   <= gfx_s1;
			col_s2   <= col_s1;
			inscr_s2 <= inscr_s1;
		end
	end

	assign glyph_bit = glyph_s2[~col_s2];
	assign fg_idx    = attr_s2[3:0];
	assign bg_idx    = attr_s2[7:4];

	always_comb begin
		if (!inscr_s2) begin
			pix_next = gfx_s2;
		end else if (glyph_bit) begin
			pix_next = txtov_pkg::FG_PALETTE[fg_idx];
		end else if (!mode_q[txtov_pkg::MODE_MIX]) begin
			pix_next = txtov_pkg::BG_PALETTE[bg_idx];
		end else if (bg_idx == txtov_pkg::BG_KEEP) begin
			pix_next = gfx_s2;
		end else if (bg_idx == txtov_pkg::BG_DIM) begin
			pix_next = txtov_pkg::halve565(gfx_s2);
		end else begin
			pix_next = txtov_pkg::BG_PALETTE[bg_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ld3 && vld_s2) begin
			pix_s3 <= pix_next;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
		end
	end

	assign pix_out.valid     = vld_s3;
	assign pix_out.pixel_out = pix_s3;
	assign pix_out.out_x     = x_s3;
	assign pix_out.out_y     = y_s3;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s3 |-> pix_in.ready)
		else $error("input not ready while the output stage is empty");

	a_font_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		font_we |=> !vld_s2)
		else $error("font write beat produced a pixel in the glyph stage");

	a_glyph_held_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !ld3) |=> (vld_s2 && $stable(glyph_s2)))
		else $error("glyph byte changed while its stage was stalled");

	a_offscreen_passes_gfx: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && ld3 && !inscr_s2) |=> (pix_out.pixel_out == $past(gfx_s2)))
		else $error("pixel beyond the screen width was not passed through");

endmodule

`default_nettype wire

@@ design/txtov_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module txtov_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ tb/text_overlay_pixel_compositor_tb.sv @@
// ----------------------------------------------------------------------------
// Text overlay pixel compositor testbench
// Drives pixel and font write beats into the compositor and predicts each
// composited pixel from a shadow font store and mode register. Results are
// checked in order against the prediction under random idling on both
// channels and one long output stall, across several video modes.
// ----------------------------------------------------------------------------
`default_nettype none

module text_overlay_pixel_compositor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_AT         = 150;
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int ITEMS_PER_PHASE = 97;
	localparam int MAX_PRINTS      = 100;

	typedef struct packed {
		logic                           req_type;
		logic [txtov_pkg::X_W-1:0]      x;
		logic [txtov_pkg::Y_W-1:0]      y;
		logic [txtov_pkg::CODE_W-1:0]   code;
		logic [txtov_pkg::ATTR_W-1:0]   attr;
		logic [txtov_pkg::PIX_W-1:0]    gfx;
		logic [txtov_pkg::FONT_AW-1:0]  font_addr;
		logic [txtov_pkg::BYTE_W-1:0]   font_data;
	} pix_req_t;

	typedef struct packed {
		logic [txtov_pkg::PIX_W-1:0]  pixel;
		logic [txtov_pkg::X_W-1:0]    x;
		logic [txtov_pkg::Y_W-1:0]    y;
	} pix_res_t;

	localparam logic [23:0] FG_RGB [16] = '{
		24'h000000, 24'h800000, 24'h008000, 24'h000080,
		24'h808000, 24'h008080, 24'h800080, 24'h404040,
		24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
		24'hffff00, 24'h00ffff, 24'hff00ff, 24'hffffff
	};

	localparam logic [23:0] BG_RGB [16] = '{
		24'h000000, 24'h800000, 24'h008000, 24'h000080,
		24'h808000, 24'h008080, 24'h800080, 24'h202020,
		24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
		24'hffff00, 24'h00ffff, 24'hff00ff, 24'hffffff
	};

	logic clk;
	logic arst_n;

	txtov_in_if  req_ch ();
	txtov_out_if res_ch ();
	txtov_cfg_if mode_ch ();

	text_overlay_pixel_compositor u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (req_ch),
		.pix_out (res_ch),
		.cfg     (mode_ch)
	);

	pix_req_t                     req_backlog [$];
	pix_res_t                     due_pixels [$];
	pix_req_t                     req_now;
	pix_res_t                     res_want;
	logic [txtov_pkg::BYTE_W-1:0] font_shadow [txtov_pkg::FONT_DEPTH];
	bit                           font_loaded [txtov_pkg::FONT_DEPTH];
	logic [txtov_pkg::MODE_W-1:0] mode_shadow;
	bit                           idle_on;
	bit                           held;
	int                           req_gap;
	int                           res_stall;
	int                           hold_left;
	int                           results_seen;
	int                           err_count;

	function automatic logic [txtov_pkg::PIX_W-1:0] to565(input logic [23:0] rgb);
		return {rgb[23:19], rgb[15:10], rgb[7:3]};
	endfunction

	function automatic logic [txtov_pkg::PIX_W-1:0] dim565(
			input logic [txtov_pkg::PIX_W-1:0] p);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = p[15:11] >> 1;
		g = p[10:5] >> 1;
		b = p[4:0] >> 1;
		return {r, g, b};
	endfunction

	function automatic logic [txtov_pkg::ROW_W-1:0] glyph_row(
			input logic [txtov_pkg::MODE_W-1:0] mode,
			input logic [txtov_pkg::Y_W-1:0] y);
		return mode[txtov_pkg::MODE_ROW60] ? y[2:0] : y[3:1];
	endfunction

	function automatic logic [txtov_pkg::PIX_W-1:0] composite_pixel(input pix_req_t r);
		logic [txtov_pkg::BYTE_W-1:0] bits;
		logic [txtov_pkg::COL_W-1:0]  col;
		logic [3:0]                   fg;
		logic [3:0]                   bg;
		if (r.x >= txtov_pkg::SCREEN_WIDTH)
			return r.gfx;
		bits = font_shadow[{r.code, glyph_row(mode_shadow, r.y)}];
		col = mode_shadow[txtov_pkg::MODE_COL80] ? r.x[2:0] : r.x[3:1];
		fg = r.attr[3:0];
		bg = r.attr[7:4];
		if (bits[7 - col])
			return to565(FG_RGB[fg]);
		if (!mode_shadow[txtov_pkg::MODE_MIX])
			return to565(BG_RGB[bg]);
		if (bg == txtov_pkg::BG_KEEP)
			return r.gfx;
		if (bg == txtov_pkg::BG_DIM)
			return dim565(r.gfx);
		return to565(BG_RGB[bg]);
	endfunction

	task automatic report_mismatch(input string field,
			input logic [txtov_pkg::PIX_W-1:0] got,
			input logic [txtov_pkg::PIX_W-1:0] want_v);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("%t mismatch on %s: got %h, expected %h", $time, field, got, want_v);
	endtask

	task automatic push_font(input logic [txtov_pkg::FONT_AW-1:0] a,
			input logic [txtov_pkg::BYTE_W-1:0] d);
		pix_req_t r;
		r.req_type  = txtov_pkg::REQ_FONT;
		r.x         = txtov_pkg::X_W'($urandom);
		r.y         = txtov_pkg::Y_W'($urandom);
		r.code      = txtov_pkg::CODE_W'($urandom);
		r.attr      = txtov_pkg::ATTR_W'($urandom);
		r.gfx       = txtov_pkg::PIX_W'($urandom);
		r.font_addr = a;
		r.font_data = d;
		font_loaded[a] = 1'b1;
		req_backlog.push_back(r);
	endtask

	task automatic push_pixel(input logic [txtov_pkg::X_W-1:0] x,
			input logic [txtov_pkg::Y_W-1:0] y,
			input logic [txtov_pkg::CODE_W-1:0] code,
			input logic [txtov_pkg::ATTR_W-1:0] attr,
			input logic [txtov_pkg::PIX_W-1:0] gfx);
		pix_req_t r;
		r.req_type  = txtov_pkg::REQ_PIXEL;
		r.x         = x;
		r.y         = y;
		r.code      = code;
		r.attr      = attr;
		r.gfx       = gfx;
		r.font_addr = txtov_pkg::FONT_AW'($urandom);
		r.font_data = txtov_pkg::BYTE_W'($urandom);
		req_backlog.push_back(r);
	endtask

	task automatic add_random_item(input logic [txtov_pkg::MODE_W-1:0] mode);
		logic [txtov_pkg::X_W-1:0]     x;
		logic [txtov_pkg::Y_W-1:0]     y;
		logic [txtov_pkg::CODE_W-1:0]  code;
		logic [txtov_pkg::FONT_AW-1:0] a;
		if ($urandom_range(0, 99) < 15) begin
			push_font(txtov_pkg::FONT_AW'($urandom_range(0, txtov_pkg::FONT_DEPTH - 1)),
				txtov_pkg::BYTE_W'($urandom));
		end else begin
			x = ($urandom_range(0, 99) < 85)
				? txtov_pkg::X_W'($urandom_range(0, txtov_pkg::SCREEN_WIDTH - 1))
				: txtov_pkg::X_W'($urandom_range(txtov_pkg::SCREEN_WIDTH, 1023));
			y = ($urandom_range(0, 99) < 90) ? txtov_pkg::Y_W'($urandom_range(0, 479))
				: txtov_pkg::Y_W'($urandom_range(480, 511));
			code = ($urandom_range(0, 1) == 0) ? txtov_pkg::CODE_W'($urandom_range(0, 7))
				: txtov_pkg::CODE_W'($urandom);
			a = {code, glyph_row(mode, y)};
			if (x < txtov_pkg::SCREEN_WIDTH && !font_loaded[a])
				push_font(a, txtov_pkg::BYTE_W'($urandom));
			push_pixel(x, y, code, txtov_pkg::ATTR_W'($urandom),
				txtov_pkg::PIX_W'($urandom));
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (req_backlog.size() != 0 || req_ch.valid || due_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input logic [txtov_pkg::MODE_W-1:0] m);
		@(posedge clk);
		mode_ch.valid <= 1'b1;
		mode_ch.video_mode <= m;
		do @(posedge clk);
		while (!mode_ch.ready);
		mode_shadow = m;
		mode_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				if (req_now.req_type == txtov_pkg::REQ_FONT)
					font_shadow[req_now.font_addr] = req_now.font_data;
				else
					due_pixels.push_back('{composite_pixel(req_now), req_now.x, req_now.y});
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_ch.valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					req_gap = $urandom_range(0, 9);
					req_ch.valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					req_now = req_backlog.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= req_now.req_type;
					req_ch.pixel_x <= req_now.x;
					req_ch.pixel_y <= req_now.y;
					req_ch.char_code <= req_now.code;
					req_ch.char_attr <= req_now.attr;
					req_ch.gfx_pixel <= req_now.gfx;
					req_ch.font_addr <= req_now.font_addr;
					req_ch.font_data <= req_now.font_data;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			res_stall = 0;
			hold_left = 0;
			held = 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (due_pixels.size() == 0) begin
					report_mismatch("pixel_out with no beat due", res_ch.pixel_out, '0);
				end else begin
					res_want = due_pixels.pop_front();
					if (res_ch.pixel_out !== res_want.pixel)
						report_mismatch("pixel_out", res_ch.pixel_out, res_want.pixel);
					if (res_ch.out_x !== res_want.x)
						report_mismatch("out_x", txtov_pkg::PIX_W'(res_ch.out_x),
							txtov_pkg::PIX_W'(res_want.x));
					if (res_ch.out_y !== res_want.y)
						report_mismatch("out_y", txtov_pkg::PIX_W'(res_ch.out_y),
							txtov_pkg::PIX_W'(res_want.y));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else if (res_stall > 0) begin
				res_stall--;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				res_stall = $urandom_range(0, 9);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (mode_ch.valid && mode_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [txtov_pkg::MODE_W-1:0] phase_modes [10];
		logic [txtov_pkg::MODE_W-1:0] m;
		phase_modes = '{4'h0, 4'hf, 4'h2, 4'h4, 4'h8, 4'h6, 4'ha, 4'hc, 4'he, 4'h0};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = txtov_pkg::REQ_PIXEL;
		req_ch.pixel_x = '0;
		req_ch.pixel_y = '0;
		req_ch.char_code = '0;
		req_ch.char_attr = '0;
		req_ch.gfx_pixel = '0;
		req_ch.font_addr = '0;
		req_ch.font_data = '0;
		res_ch.ready = 1'b0;
		mode_ch.valid = 1'b0;
		mode_ch.video_mode = '0;
		mode_shadow = '0;
		idle_on = 1'b1;
		results_seen = 0;
		err_count = 0;
		foreach (font_loaded[i])
			font_loaded[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset mode: 40 columns, 30 rows, text only.
		push_font(11'd0, 8'h81);
		push_font(11'd2047, 8'hff);
		push_font({8'haa, 3'd5}, 8'h5a);
		push_pixel(10'd0, 9'd0, 8'h00, 8'hf0, 16'h1234);
		push_pixel(10'd2, 9'd1, 8'h00, 8'h7a, 16'h0000);
		push_pixel(10'd15, 9'd0, 8'h00, 8'h0f, 16'hffff);
		push_pixel(10'd8, 9'd0, 8'h00, 8'h8f, 16'hffff);
		push_pixel(10'd639, 9'd479, 8'hff, 8'h95, 16'hffff);
		push_pixel(10'd639, 9'd511, 8'hff, 8'h80, 16'habcd);
		push_pixel(10'd640, 9'd0, 8'h12, 8'hff, 16'h1234);
		push_pixel(10'd1023, 9'd511, 8'h00, 8'h00, 16'hffff);
		drain();

		// Mix mode with 8-pixel cells in both directions.
		set_mode(4'hf);
		push_pixel(10'd0, 9'd5, 8'haa, 8'h30, 16'hf0f0);
		push_pixel(10'd8, 9'd13, 8'haa, 8'h00, 16'h1357);
		push_pixel(10'd16, 9'd5, 8'haa, 8'h80, 16'hffff);
		push_pixel(10'd1, 9'd5, 8'haa, 8'h0c, 16'h0000);
		push_pixel(10'd7, 9'd21, 8'haa, 8'h8f, 16'h0841);
		push_pixel(10'd639, 9'd479, 8'hff, 8'h3e, 16'h0000);
		push_pixel(10'd1000, 9'd5, 8'haa, 8'h80, 16'hffff);
		drain();

		foreach (phase_modes[p]) begin
			m = phase_modes[p] | txtov_pkg::MODE_W'($urandom_range(0, 1));
			set_mode(m);
			if (p == $size(phase_modes) - 1)
				idle_on = 1'b0;
			repeat (ITEMS_PER_PHASE)
				add_random_item(m);
			drain();
		end

		if (err_count == 0 && due_pixels.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
